// ----- src/sbrt_pkg.sv -----
// Shared types and constants for the spare block remap table.
package sbrt_pkg;

    // Table geometry
    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int LIM_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int FREE_W        = 11;
    localparam logic [FREE_W-1:0] FREE_MAX = {FREE_W{1'b1}};

    // Configuration port
    localparam int APB_ADDR_W = 4;
    localparam logic [1:0] REG_ENABLE   = 2'd0;
    localparam logic [1:0] REG_PKT_LOG2 = 2'd1;
    localparam logic [1:0] REG_ENTRIES  = 2'd2;

    // Original location marker words
    localparam logic [31:0] LOC_AVAILABLE = 32'hFFFF_FFFF;
    localparam logic [31:0] LOC_CORRUPTED = 32'hFFFF_FFF0;

    // Operation codes
    localparam logic [2:0] KIND_LOAD     = 3'd0;
    localparam logic [2:0] KIND_RELOCATE = 3'd1;
    localparam logic [2:0] KIND_REMAP    = 3'd2;
    localparam logic [2:0] KIND_UNMAP    = 3'd3;
    localparam logic [2:0] KIND_OVERLAP  = 3'd4;

    // Result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_REMAPPED = 2'd2;
    localparam logic [1:0] STAT_NO_TABLE = 2'd3;

    typedef struct packed {
        logic        enabled;
        logic [3:0]  pkt_log2;
        logic [10:0] entries;
    } cfg_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic             wr_spare_en;
        logic [IDX_W-1:0] wr_addr;
        logic [31:0]      wr_orig;
        logic [31:0]      wr_spare;
    } mem_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] phys;
        logic        ovl;
        logic        modified;
    } res_t;

endpackage

// ----- src/sbrt_table_mem.sv -----
// Original and spare location memories, one write port and one registered read port.
module sbrt_table_mem (
    input  logic               clk,
    input  sbrt_pkg::mem_req_t mem_req,
    output logic [31:0]        rd_orig,
    output logic [31:0]        rd_spare
);
    import sbrt_pkg::*;

    logic [31:0] orig_mem  [TABLE_ENTRIES];
    logic [31:0] spare_mem [TABLE_ENTRIES];
    logic [31:0] rd_orig_reg;
    logic [31:0] rd_spare_reg;

    // Write the addressed entry
    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            orig_mem[mem_req.wr_addr] <= mem_req.wr_orig;
        end
        if (mem_req.wr_spare_en)
        begin
            spare_mem[mem_req.wr_addr] <= mem_req.wr_spare;
        end
    end

    // Read both words of one entry, data in the next cycle
    always_ff @(posedge clk)
    begin
        if (mem_req.rd_en)
        begin
            rd_orig_reg  <= orig_mem[mem_req.rd_addr];
            rd_spare_reg <= spare_mem[mem_req.rd_addr];
        end
    end

    assign rd_orig  = rd_orig_reg;
    assign rd_spare = rd_spare_reg;

endmodule

// ----- src/sbrt_scan_ctrl.sv -----
// Operation sequencer: scans the table memory and applies read-modify-write updates.
module sbrt_scan_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               busy,
    input  logic [2:0]         kind,
    input  logic [31:0]        lba,
    input  logic [31:0]        block_count,
    input  logic               remap_spared,
    input  logic [9:0]         entry_index,
    input  logic [31:0]        entry_original,
    input  logic [31:0]        entry_spare,
    input  sbrt_pkg::cfg_t     cfg,
    output sbrt_pkg::mem_req_t mem_req,
    input  logic [31:0]        rd_orig,
    input  logic [31:0]        rd_spare,
    output logic               res_valid,
    output sbrt_pkg::res_t     res,
    input  logic               res_take
);
    import sbrt_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_LOOK   = 4'd1;
    localparam logic [3:0] ST_OVL    = 4'd2;
    localparam logic [3:0] ST_UNMAP  = 4'd3;
    localparam logic [3:0] ST_COUNT1 = 4'd4;
    localparam logic [3:0] ST_MATCH  = 4'd5;
    localparam logic [3:0] ST_COUNT2 = 4'd6;
    localparam logic [3:0] ST_CLAIM  = 4'd7;
    localparam logic [3:0] ST_DONE   = 4'd8;

    // Control state
    logic [3:0]        state_reg,      state_next;
    logic [LIM_W-1:0]  rd_idx_reg,     rd_idx_next;
    logic              p_vld_reg,      p_vld_next;
    logic [FREE_W-1:0] free_count_reg, free_count_next;
    logic              free_known_reg, free_known_next;
    logic              modified_reg,   modified_next;

    // Operation payload
    logic [IDX_W-1:0]  p_idx_reg,   p_idx_next;
    logic [LIM_W-1:0]  lim_reg,     lim_next;
    logic [FREE_W-1:0] count_reg,   count_next;
    logic [IDX_W-1:0]  m_idx_reg,   m_idx_next;
    logic [31:0]       lba_reg,     lba_next;
    logic [31:0]       mask_reg,    mask_next;
    logic [31:0]       aligned_reg, aligned_next;
    logic [15:0]       bs_reg,      bs_next;
    logic [31:0]       end_reg,     end_next;
    logic [31:0]       last_reg,    last_next;
    logic              spared_reg,  spared_next;
    logic [1:0]        status_reg,  status_next;
    logic [31:0]       phys_reg,    phys_next;
    logic              ovl_reg,     ovl_next;

    // Evaluation of the entry just read
    logic [31:0] o_end;
    logic        is_mark;
    logic        avail;
    logic        pkt_hit;
    logic        unmap_hit;
    logic        ovl_hit;
    logic        stop;
    logic        scanning;
    logic        rd_more;
    logic        rd_en;
    logic        scan_done;
    logic [31:0] start_mask;
    logic [31:0] start_end;

    assign o_end     = rd_orig + {16'd0, bs_reg};
    assign is_mark   = (rd_orig == LOC_AVAILABLE) || (rd_orig == LOC_CORRUPTED);
    assign avail     = (rd_orig == LOC_AVAILABLE);
    assign pkt_hit   = !is_mark && ((rd_orig & mask_reg) == aligned_reg);
    assign unmap_hit = !is_mark && (rd_orig >= lba_reg) && (o_end <= end_reg);
    assign ovl_hit   = !is_mark &&
                       (((lba_reg >= rd_orig) && (lba_reg < o_end)) ||
                        ((last_reg >= rd_orig) && (last_reg < o_end)) ||
                        ((rd_orig >= lba_reg) && (rd_orig < end_reg)) ||
                        ((o_end >= lba_reg) && (o_end < end_reg)));

    // First-match scans stop at the hit
    always_comb
    begin
        case (state_reg)
            ST_LOOK:  stop = p_vld_reg && pkt_hit;
            ST_MATCH: stop = p_vld_reg && pkt_hit;
            ST_OVL:   stop = p_vld_reg && ovl_hit;
            ST_CLAIM: stop = p_vld_reg && avail;
            default:  stop = 1'b0;
        endcase
    end

    assign scanning  = state_reg inside {ST_LOOK, ST_OVL, ST_UNMAP, ST_COUNT1,
                                         ST_MATCH, ST_COUNT2, ST_CLAIM};
    assign rd_more   = rd_idx_reg < lim_reg;
    assign rd_en     = scanning && rd_more && !stop;
    assign scan_done = !p_vld_reg && !rd_more;

    assign start_mask = ~((32'd1 << cfg.pkt_log2) - 32'd1);
    assign start_end  = lba + block_count;

    always_comb
    begin
        state_next      = state_reg;
        rd_idx_next     = rd_idx_reg;
        p_vld_next      = 1'b0;
        p_idx_next      = rd_idx_reg[IDX_W-1:0];
        free_count_next = free_count_reg;
        free_known_next = free_known_reg;
        modified_next   = modified_reg;
        lim_next        = lim_reg;
        count_next      = count_reg;
        m_idx_next      = m_idx_reg;
        lba_next        = lba_reg;
        mask_next       = mask_reg;
        aligned_next    = aligned_reg;
        bs_next         = bs_reg;
        end_next        = end_reg;
        last_next       = last_reg;
        spared_next     = spared_reg;
        status_next     = status_reg;
        phys_next       = phys_reg;
        ovl_next        = ovl_reg;

        mem_req             = '0;
        mem_req.rd_en       = rd_en;
        mem_req.rd_addr     = rd_idx_reg[IDX_W-1:0];
        mem_req.wr_addr     = p_idx_reg;

        // Advance the read pointer
        if (rd_en)
        begin
            rd_idx_next = rd_idx_reg + LIM_W'(1);
            p_vld_next  = 1'b1;
        end

        // Tally available entries during a recount
        if ((state_reg == ST_COUNT1 || state_reg == ST_COUNT2) && p_vld_reg && avail)
        begin
            count_next = count_reg + FREE_W'(1);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    lba_next     = lba;
                    mask_next    = start_mask;
                    aligned_next = lba & start_mask;
                    bs_next      = 16'd1 << cfg.pkt_log2;
                    end_next     = start_end;
                    last_next    = start_end - 32'd1;
                    spared_next  = remap_spared;
                    if (int'(cfg.entries) > TABLE_ENTRIES)
                    begin
                        lim_next = LIM_W'(TABLE_ENTRIES);
                    end
                    else
                    begin
                        lim_next = LIM_W'(cfg.entries);
                    end
                    status_next = STAT_OK;
                    ovl_next    = 1'b0;
                    phys_next   = (kind == KIND_RELOCATE) ? lba : 32'd0;
                    rd_idx_next = '0;
                    count_next  = '0;
                    state_next  = ST_DONE;
                    case (kind)
                        KIND_LOAD:
                        begin
                            if (int'(entry_index) < TABLE_ENTRIES)
                            begin
                                mem_req.wr_en       = 1'b1;
                                mem_req.wr_spare_en = 1'b1;
                                mem_req.wr_addr     = IDX_W'(entry_index);
                                mem_req.wr_orig     = entry_original;
                                mem_req.wr_spare    = entry_spare;
                                free_known_next     = 1'b0;
                            end
                        end
                        KIND_RELOCATE:
                        begin
                            if (cfg.enabled)
                            begin
                                state_next = ST_LOOK;
                            end
                        end
                        KIND_REMAP:
                        begin
                            if (!cfg.enabled)
                            begin
                                status_next = STAT_NO_TABLE;
                            end
                            else if (!free_known_reg)
                            begin
                                state_next = ST_COUNT1;
                            end
                            else if (free_count_reg == '0)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                state_next = ST_MATCH;
                            end
                        end
                        KIND_UNMAP:
                        begin
                            if (cfg.enabled)
                            begin
                                state_next = ST_UNMAP;
                            end
                        end
                        KIND_OVERLAP:
                        begin
                            if (cfg.enabled)
                            begin
                                state_next = ST_OVL;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_LOOK:
            begin
                if (stop)
                begin
                    phys_next  = rd_spare + lba_reg - rd_orig;
                    state_next = ST_DONE;
                end
                else if (scan_done)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_OVL:
            begin
                if (stop)
                begin
                    ovl_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else if (scan_done)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_UNMAP:
            begin
                // Release entries wholly inside the range
                if (p_vld_reg && unmap_hit)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_orig = LOC_AVAILABLE;
                    modified_next   = 1'b1;
                    if (free_known_reg && free_count_reg < FREE_MAX)
                    begin
                        free_count_next = free_count_reg + FREE_W'(1);
                    end
                end
                if (scan_done)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_COUNT1:
            begin
                if (scan_done)
                begin
                    free_count_next = count_reg;
                    free_known_next = 1'b1;
                    rd_idx_next     = '0;
                    count_next      = '0;
                    if (count_reg == '0)
                    begin
                        status_next = STAT_FULL;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_MATCH;
                    end
                end
            end

            ST_MATCH:
            begin
                if (stop)
                begin
                    m_idx_next  = p_idx_reg;
                    p_vld_next  = 1'b0;
                    rd_idx_next = '0;
                    count_next  = '0;
                    state_next  = ST_COUNT2;
                end
                else if (scan_done)
                begin
                    rd_idx_next = '0;
                    state_next  = ST_CLAIM;
                end
            end

            ST_COUNT2:
            begin
                if (scan_done)
                begin
                    free_count_next = count_reg;
                    free_known_next = 1'b1;
                    rd_idx_next     = '0;
                    if (count_reg == '0)
                    begin
                        status_next = STAT_FULL;
                        state_next  = ST_DONE;
                    end
                    else if (!spared_reg)
                    begin
                        status_next = STAT_REMAPPED;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        // Retire the old mapping before claiming a new entry
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = m_idx_reg;
                        mem_req.wr_orig = LOC_CORRUPTED;
                        modified_next   = 1'b1;
                        state_next      = ST_CLAIM;
                    end
                end
            end

            ST_CLAIM:
            begin
                if (stop)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_orig = aligned_reg;
                    modified_next   = 1'b1;
                    if (free_count_reg != '0)
                    begin
                        free_count_next = free_count_reg - FREE_W'(1);
                    end
                    status_next = STAT_OK;
                    state_next  = ST_DONE;
                end
                else if (scan_done)
                begin
                    status_next = STAT_FULL;
                    state_next  = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rd_idx_reg     <= '0;
            p_vld_reg      <= 1'b0;
            free_count_reg <= '0;
            free_known_reg <= 1'b0;
            modified_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_idx_reg     <= rd_idx_next;
            p_vld_reg      <= p_vld_next;
            free_count_reg <= free_count_next;
            free_known_reg <= free_known_next;
            modified_reg   <= modified_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        p_idx_reg   <= p_idx_next;
        lim_reg     <= lim_next;
        count_reg   <= count_next;
        m_idx_reg   <= m_idx_next;
        lba_reg     <= lba_next;
        mask_reg    <= mask_next;
        aligned_reg <= aligned_next;
        bs_reg      <= bs_next;
        end_reg     <= end_next;
        last_reg    <= last_next;
        spared_reg  <= spared_next;
        status_reg  <= status_next;
        phys_reg    <= phys_next;
        ovl_reg     <= ovl_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign res_valid    = (state_reg == ST_DONE);
    assign res.status   = status_reg;
    assign res.phys     = phys_reg;
    assign res.ovl      = ovl_reg;
    assign res.modified = modified_reg;

endmodule

// ----- src/spare_block_remap_table_unit.sv -----
// Top level of the spare block remap table: configuration port, sequencer, memory, result register.
//
// Input channel (in_valid/in_stall) carries one operation per beat: load entry, relocate
// sector, remap packet, unmap range or overlap test. Output channel (out_valid/out_stall)
// returns exactly one result beat per operation, in order.
// One operation is processed at a time. Relocate, unmap and overlap test scan the table once
// through the single memory read port, one entry per cycle, over the searched entries (at
// most 1024). A remap runs up to four such scans (recount, match, recount, claim).
// in_stall is high while an operation is being worked on; a finished result sits in the
// output register, so the next operation is taken while that result waits.
// When the receiver stalls, the result is held; a following operation completes its work
// and then waits until the output register is free.
// Reset empties the pipeline, marks the free count unknown, clears the modified mark and
// sets the registers to table enabled, 32-sector packets and 1024 searched entries.
// Table contents are undefined until loaded; no clearing pass is run.
// Registers sit at byte addresses 0 (enable), 4 (packet size log2), 8 (entries in use).
module spare_block_remap_table_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sbrt_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [2:0]                      kind,
    input  logic [31:0]                     lba,
    input  logic [31:0]                     block_count,
    input  logic                            remap_spared,
    input  logic [9:0]                      entry_index,
    input  logic [31:0]                     entry_original,
    input  logic [31:0]                     entry_spare,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      status,
    output logic [31:0]                     physical_lba,
    output logic                            overlaps,
    output logic                            table_modified
);
    import sbrt_pkg::*;

    cfg_t        cfg;
    mem_req_t    mem_req;
    res_t        res;
    logic [31:0] rd_orig;
    logic [31:0] rd_spare;
    logic        busy;
    logic        res_valid;
    logic        res_take;
    logic        cfg_wr;

    logic        enabled_reg;
    logic [3:0]  pkt_log2_reg;
    logic [10:0] entries_reg;
    logic        out_valid_reg;
    res_t        out_reg;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg  <= 1'b1;
            pkt_log2_reg <= 4'd5;
            entries_reg  <= 11'd1024;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_ENABLE:   enabled_reg  <= pwdata[0];
                REG_PKT_LOG2: pkt_log2_reg <= pwdata[3:0];
                REG_ENTRIES:  entries_reg  <= pwdata[10:0];
                default:      ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        case (paddr[3:2])
            REG_ENABLE:   prdata = {31'd0, enabled_reg};
            REG_PKT_LOG2: prdata = {28'd0, pkt_log2_reg};
            REG_ENTRIES:  prdata = {21'd0, entries_reg};
            default:      prdata = 32'd0;
        endcase
    end

    assign cfg.enabled  = enabled_reg;
    assign cfg.pkt_log2 = pkt_log2_reg;
    assign cfg.entries  = entries_reg;

    sbrt_scan_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .busy           (busy),
        .kind           (kind),
        .lba            (lba),
        .block_count    (block_count),
        .remap_spared   (remap_spared),
        .entry_index    (entry_index),
        .entry_original (entry_original),
        .entry_spare    (entry_spare),
        .cfg            (cfg),
        .mem_req        (mem_req),
        .rd_orig        (rd_orig),
        .rd_spare       (rd_spare),
        .res_valid      (res_valid),
        .res            (res),
        .res_take       (res_take)
    );

    sbrt_table_mem u_mem (
        .clk      (clk),
        .mem_req  (mem_req),
        .rd_orig  (rd_orig),
        .rd_spare (rd_spare)
    );

    assign in_stall = busy;

    // Output register: take a result when empty or being drained
    assign res_take = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_take)
        begin
            out_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_reg.status;
    assign physical_lba   = out_reg.phys;
    assign overlaps       = out_reg.ovl;
    assign table_modified = out_reg.modified;

`ifndef SYNTHESIS
    // The modified mark never clears once set
    a_modified_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        res.modified |=> res.modified)
        else $error("modified mark cleared");

    // An overlap hit always carries a success status
    a_overlap_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && overlaps) |-> (status == STAT_OK))
        else $error("overlap reported with failing status");

    // The scan never reads the entry it is writing back
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_req.wr_en && mem_req.rd_en) |-> (mem_req.wr_addr != mem_req.rd_addr))
        else $error("read and write to the same entry in one cycle");
`endif

endmodule
